FILE: rtl/core/apq_pkg.sv
package apq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CFG_W = 5;

  localparam int ID_W   = 16;
  localparam int PAGE_W = 8;
  localparam int PRIO_W = 4;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PAGE_W-1:0] pages;
    logic [ID_W-1:0]   id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    op_t    op;
    entry_t entry;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    entry_t           entry;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } result_t;

  // entry store access from the back end
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: rtl/core/array_priority_queue.sv
// channel   dir  handshake          payload
// in_       in   in_tvalid/tready   tdata: entry_id, entry_pages, entry_priority
//                                   tuser: operation
// out_      out  out_tvalid/tready  tdata: out_id, out_pages, out_priority,
//                                          count, is_empty, is_full
//                                   tuser: status
// cfg_      in   cfg_wr_en          cfg_wr_data: capacity_in_use
//
// add, clear and no-op go from idle straight to the response state in the back end;
// extract on a non-empty queue reads every entry through the single read port of
// the entry store to scan for the maximum, then moves each entry after it down
// a two-deep command queue lets the input side take transactions while the
// back end works; the output register holds a result until it is taken
// reset (rst_n low, synchronous) empties the queue and sets capacity to DEPTH;
// store contents are left as they are
module array_priority_queue (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] entry_id, [23:16] entry_pages,
                                  // [27:24] entry_priority, [31:28] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] out_id, [23:16] out_pages,
                                  // [27:24] out_priority, [32:28] count,
                                  // [33] is_empty, [34] is_full, [39:35] zero
  output logic [1:0]  out_tuser,  // [1:0] status

  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data // capacity_in_use
);

  localparam int CNT_FIELD_W = 5;

  logic [apq_pkg::CFG_W-1:0] cap_r;
  logic [apq_pkg::CNT_W-1:0] cap_eff;

  logic              cmd_valid;
  apq_pkg::cmd_t     cmd;
  logic              cmd_pop;
  apq_pkg::ram_req_t ram_req;
  apq_pkg::entry_t   ram_rdata;
  logic              res_valid;
  apq_pkg::result_t  res;

  // capacity register, reset to full depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= apq_pkg::CFG_W'(apq_pkg::DEPTH);
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // clamp capacity into 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = apq_pkg::CNT_W'(1);
    end else if (32'(cap_r) > apq_pkg::DEPTH) begin
      cap_eff = apq_pkg::CNT_W'(apq_pkg::DEPTH);
    end else begin
      cap_eff = apq_pkg::CNT_W'(cap_r);
    end
  end

  apq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  apq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cap       (cap_eff),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_valid (res_valid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // entry store
  apq_ram #(
    .WIDTH (apq_pkg::ENTRY_W),
    .DEPTH (apq_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // result packing
  assign out_tvalid       = res_valid;
  assign out_tuser        = res.status;
  assign out_tdata[15:0]  = res.entry.id;
  assign out_tdata[23:16] = res.entry.pages;
  assign out_tdata[27:24] = res.entry.prio;
  assign out_tdata[32:28] = CNT_FIELD_W'(res.count);
  assign out_tdata[33]    = res.is_empty;
  assign out_tdata[34]    = res.is_full;
  assign out_tdata[39:35] = '0;

`ifndef SYNTHESIS
  // empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33] == (out_tdata[32:28] == 5'd0)))
    else $error("is_empty disagrees with count");

  // count never exceeds the store depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[32:28]) <= apq_pkg::DEPTH))
    else $error("count beyond depth");

  // a dropped add only happens when the queue reports full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == apq_pkg::ST_FULL) |-> out_tdata[34])
    else $error("add dropped while not full");

  // extract on empty returns a zero payload and an empty queue
  a_empty_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == apq_pkg::ST_EMPTY) |->
      (out_tdata[27:0] == 28'd0 && out_tdata[33]))
    else $error("extract on empty with payload");
`endif

endmodule

FILE: rtl/core/apq_ram.sv
module apq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/apq_front.sv
module apq_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [31:0]     in_tdata,
  input  logic [1:0]      in_tuser,
  output logic            cmd_valid,
  output apq_pkg::cmd_t   cmd,
  input  logic            cmd_pop
);

  // two-entry command queue
  apq_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    fill_r;
  apq_pkg::cmd_t cmd_in;
  logic          push;
  logic          pop;

  always_comb begin
    cmd_in.op          = apq_pkg::op_t'(in_tuser);
    cmd_in.entry.id    = in_tdata[apq_pkg::ID_W-1:0];
    cmd_in.entry.pages = in_tdata[apq_pkg::ID_W +: apq_pkg::PAGE_W];
    cmd_in.entry.prio  = in_tdata[apq_pkg::ID_W + apq_pkg::PAGE_W +: apq_pkg::PRIO_W];
  end

  assign in_tready = (fill_r != 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      fill_r <= fill_r + 2'd1;
      else if (pop && !push) fill_r <= fill_r - 2'd1;
    end
  end

endmodule

FILE: rtl/core/apq_back.sv
module apq_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  apq_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  input  logic [apq_pkg::CNT_W-1:0]   cap,
  output apq_pkg::ram_req_t           ram_req,
  input  apq_pkg::entry_t             ram_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output apq_pkg::result_t            out_res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t                    state_r, state_nxt;
  logic [apq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [apq_pkg::CNT_W-1:0] ptr_r, ptr_nxt;
  logic [apq_pkg::IDX_W-1:0] best_idx_r, best_idx_nxt;
  apq_pkg::entry_t           best_r, best_nxt;
  apq_pkg::result_t          res_r, res_nxt;
  logic                      out_valid_r;
  apq_pkg::result_t          out_res_r;

  logic [apq_pkg::CNT_W-1:0] ptr_inc;
  logic [apq_pkg::CNT_W-1:0] ptr_dec;
  logic                      take_cur;
  logic [apq_pkg::CNT_W-1:0] shift_start;
  logic [apq_pkg::CNT_W-1:0] count_dec;

  assign ptr_inc     = ptr_r + 1'b1;
  assign ptr_dec     = ptr_r - 1'b1;
  // entry under the scan becomes the new best; strict compare keeps the earliest on ties
  assign take_cur    = (ptr_r == '0) || (ram_rdata.prio > best_r.prio);
  assign shift_start = (take_cur ? ptr_r : apq_pkg::CNT_W'(best_idx_r)) + 1'b1;
  assign count_dec   = count_r - 1'b1;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    res_nxt      = res_r;
    cmd_pop      = 1'b0;
    ram_req      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop          = 1'b1;
          res_nxt.status   = apq_pkg::ST_DONE;
          res_nxt.entry    = '0;
          state_nxt        = S_RESP;
          unique case (cmd.op)
            apq_pkg::OP_ADD: begin
              if (count_r >= cap) begin
                res_nxt.status = apq_pkg::ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count_r[apq_pkg::IDX_W-1:0];
                ram_req.wdata = cmd.entry;
                count_nxt     = count_r + 1'b1;
              end
            end
            apq_pkg::OP_EXTRACT: begin
              if (count_r == '0) begin
                res_nxt.status = apq_pkg::ST_EMPTY;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
                ptr_nxt       = '0;
                state_nxt     = S_SCAN;
              end
            end
            apq_pkg::OP_CLEAR: count_nxt = '0;
            apq_pkg::OP_NOP:   count_nxt = count_r;
            default:           count_nxt = count_r;
          endcase
        end
      end

      S_SCAN: begin
        // ram_rdata holds entry ptr_r
        if (take_cur) begin
          best_nxt     = ram_rdata;
          best_idx_nxt = ptr_r[apq_pkg::IDX_W-1:0];
        end
        if (ptr_inc < count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_inc[apq_pkg::IDX_W-1:0];
          ptr_nxt       = ptr_inc;
        end else if (shift_start < count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = shift_start[apq_pkg::IDX_W-1:0];
          ptr_nxt       = shift_start;
          state_nxt     = S_SHIFT;
        end else begin
          count_nxt     = count_dec;
          res_nxt.entry = best_nxt;
          state_nxt     = S_RESP;
        end
      end

      S_SHIFT: begin
        // move entry ptr_r down one place
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_dec[apq_pkg::IDX_W-1:0];
        ram_req.wdata = ram_rdata;
        if (ptr_inc < count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_inc[apq_pkg::IDX_W-1:0];
          ptr_nxt       = ptr_inc;
        end else begin
          count_nxt     = count_dec;
          res_nxt.entry = best_r;
          state_nxt     = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    res_nxt.count    = count_nxt;
    res_nxt.is_empty = (count_nxt == '0);
    res_nxt.is_full  = (count_nxt >= cap);
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    if (state_r != S_RESP) begin
      res_r <= res_nxt;
    end
    if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
      out_res_r <= res_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
